/* design/hsvis_pkg.sv */
// ----------------------------------------------------------------------------
// hsvis_pkg
// shared widths, constants, codes and types of the hsv illumination shader
// ----------------------------------------------------------------------------
package hsvis_pkg;

  localparam int FRAC_BITS = 12;
  localparam int CW        = FRAC_BITS + 1;     // channel width, Q1.FRAC
  localparam int IW        = FRAC_BITS + 2;     // intensity width, signed
  localparam int QW        = FRAC_BITS + 1;     // quotient bits, one per divider stage
  localparam int RW        = FRAC_BITS + 2;     // divider remainder width
  localparam int HW        = FRAC_BITS + 3;     // hue width, sector and fraction
  localparam int PW        = 2 * CW;            // 13x13 product width
  localparam int WW        = 2 * FRAC_BITS + 1; // width of one squared
  localparam int LW        = CW + WW;           // long product width

  localparam logic [CW-1:0] ONE      = CW'(1) << FRAC_BITS;
  localparam logic [PW-1:0] HALF     = PW'(1) << (FRAC_BITS - 1);
  localparam logic [WW-1:0] ONE_SQ   = WW'(1) << (2 * FRAC_BITS);
  localparam logic [LW-1:0] HALF_SQ  = LW'(1) << (2 * FRAC_BITS - 1);
  localparam logic [HW-1:0] HUE_WRAP = HW'(6) << FRAC_BITS;

  // which channel holds the maximum
  localparam logic [1:0] SEL_RED   = 2'd0;
  localparam logic [1:0] SEL_GREEN = 2'd1;
  localparam logic [1:0] SEL_BLUE  = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_BRIGHT_SAT = 2'd0;
  localparam logic [1:0] REG_BRIGHT_VAL = 2'd1;
  localparam logic [1:0] REG_DARK_SAT   = 2'd2;
  localparam logic [1:0] REG_DARK_VAL   = 2'd3;

  // per-item sideband carried alongside the dividers
  typedef struct packed {
    logic [CW-1:0] r;
    logic [CW-1:0] g;
    logic [CW-1:0] b;
    logic [CW-1:0] cmax;
    logic          delta_zero;
    logic [2:0]    base;
    logic          hneg;
    logic [CW-1:0] w;
    logic          neg;
    logic          pass;
  } side_t;

  function automatic logic [CW-1:0] sat_one(input logic [CW-1:0] x);
    sat_one = (x > ONE) ? ONE : x;
  endfunction

endpackage

/* design/hsvis_div.sv */
// ----------------------------------------------------------------------------
// hsvis_div
// pipelined restoring divider, (num << FRAC_BITS) / den, one quotient bit a stage
// ----------------------------------------------------------------------------
module hsvis_div (
  input  logic                        clk,
  input  logic [hsvis_pkg::QW-1:0]    en,
  input  logic [hsvis_pkg::CW-1:0]    num,
  input  logic [hsvis_pkg::CW-1:0]    den,
  output logic [hsvis_pkg::QW-1:0]    quo
);

  logic [hsvis_pkg::RW-1:0] rem  [hsvis_pkg::QW];
  logic [hsvis_pkg::QW-1:0] qacc [hsvis_pkg::QW];
  logic [hsvis_pkg::CW-1:0] dens [hsvis_pkg::QW];

  // num <= den, so the quotient fits in QW bits
  always_ff @(posedge clk) begin
    if (en[0]) begin
      if (hsvis_pkg::RW'(num) >= hsvis_pkg::RW'(den)) begin
        rem[0]  <= (hsvis_pkg::RW'(num) - hsvis_pkg::RW'(den)) << 1;
        qacc[0] <= hsvis_pkg::QW'(1);
      end else begin
        rem[0]  <= hsvis_pkg::RW'(num) << 1;
        qacc[0] <= '0;
      end
      dens[0] <= den;
    end
  end

  for (genvar j = 1; j < hsvis_pkg::QW; j++) begin : g_stage
    always_ff @(posedge clk) begin
      if (en[j]) begin
        if (rem[j-1] >= hsvis_pkg::RW'(dens[j-1])) begin
          rem[j]  <= (rem[j-1] - hsvis_pkg::RW'(dens[j-1])) << 1;
          qacc[j] <= {qacc[j-1][hsvis_pkg::QW-2:0], 1'b1};
        end else begin
          rem[j]  <= rem[j-1] << 1;
          qacc[j] <= {qacc[j-1][hsvis_pkg::QW-2:0], 1'b0};
        end
        dens[j] <= dens[j-1];
      end
    end
  end

  assign quo = qacc[hsvis_pkg::QW-1];

endmodule

/* design/hsv_illumination_shade_core.sv */
// ----------------------------------------------------------------------------
// hsv_illumination_shade_core
// per-pixel relief shading: rgb to hsv, blend s and v toward targets, back to rgb
// ----------------------------------------------------------------------------
// throughput: one item per cycle when nothing stalls; a new item may then enter every cycle
// the two 13-stage dividers (hue fraction and saturation) set the depth
// each stage advances when it is empty or the stage after it moves
// reset: synchronous, clears all valid bits and loads the register defaults
// ----------------------------------------------------------------------------
module hsv_illumination_shade_core (
  input  logic                      clk,
  input  logic                      rst,
  // configuration write port
  input  logic                      cfg_write,
  input  logic [1:0]                cfg_index,
  input  logic [hsvis_pkg::CW-1:0]  cfg_data,
  // input channel
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [hsvis_pkg::CW-1:0]  red_in,
  input  logic [hsvis_pkg::CW-1:0]  green_in,
  input  logic [hsvis_pkg::CW-1:0]  blue_in,
  input  logic [hsvis_pkg::IW-1:0]  intensity,
  input  logic                      intensity_null,
  // output channel
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [hsvis_pkg::CW-1:0]  red_out,
  output logic [hsvis_pkg::CW-1:0]  green_out,
  output logic [hsvis_pkg::CW-1:0]  blue_out
);

  localparam int CW = hsvis_pkg::CW;
  localparam int QW = hsvis_pkg::QW;
  // stage map: 0 input, 1 max/min, 2 hue setup, 3..3+QW-1 dividers, then 5 more
  localparam int SD = 3;
  localparam int SH = SD + QW;     // hue assembly and blend products
  localparam int SB = SH + 1;      // blend sums
  localparam int SP = SB + 1;      // first products of the hsv to rgb step
  localparam int SQ = SP + 1;      // long products
  localparam int SO = SQ + 1;      // output register
  localparam int NS = SO + 1;

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic [CW-1:0] bright_saturation, bright_value, dark_saturation, dark_value;

  always_ff @(posedge clk) begin
    if (rst) begin
      bright_saturation <= hsvis_pkg::ONE;
      bright_value      <= hsvis_pkg::ONE;
      dark_saturation   <= '0;
      dark_value        <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        hsvis_pkg::REG_BRIGHT_SAT: bright_saturation <= cfg_data;
        hsvis_pkg::REG_BRIGHT_VAL: bright_value      <= cfg_data;
        hsvis_pkg::REG_DARK_SAT:   dark_saturation   <= cfg_data;
        hsvis_pkg::REG_DARK_VAL:   dark_value        <= cfg_data;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // valid bits and per-stage advance; a stage moves when empty or drained
  // --------------------------------------------------------------------------
  logic [NS-1:0] vld;
  logic [NS-1:0] en;

  always_comb begin
    en[NS-1] = !vld[NS-1] || !out_stall;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= in_valid;
      for (int k = 1; k < NS; k++) begin
        if (en[k]) vld[k] <= vld[k-1];
      end
    end
  end

  assign in_stall  = !en[0];
  assign out_valid = vld[NS-1];

  // --------------------------------------------------------------------------
  // stage 0: saturate channels, clamp intensity to +-1 as sign and magnitude
  // --------------------------------------------------------------------------
  logic signed [hsvis_pkg::IW:0] it_ext;
  logic [hsvis_pkg::IW:0]        it_abs;
  logic [CW-1:0] s0_r, s0_g, s0_b, s0_w;
  logic          s0_neg, s0_pass;

  always_comb begin
    it_ext = {intensity[hsvis_pkg::IW-1], intensity};
    it_abs = intensity[hsvis_pkg::IW-1] ? unsigned'(-it_ext) : unsigned'(it_ext);
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s0_r    <= hsvis_pkg::sat_one(red_in);
      s0_g    <= hsvis_pkg::sat_one(green_in);
      s0_b    <= hsvis_pkg::sat_one(blue_in);
      s0_w    <= (it_abs > (hsvis_pkg::IW+1)'(hsvis_pkg::ONE)) ? hsvis_pkg::ONE : CW'(it_abs);
      s0_neg  <= intensity[hsvis_pkg::IW-1];
      // no data or zero intensity passes the colour through
      s0_pass <= intensity_null || (intensity == '0);
    end
  end

  // --------------------------------------------------------------------------
  // stage 1: max, min and which channel leads
  // --------------------------------------------------------------------------
  logic [CW-1:0] c1_max, c1_min, c1_rg_max, c1_rg_min;
  logic [1:0]    c1_sel;
  logic [CW-1:0] s1_r, s1_g, s1_b, s1_max, s1_min, s1_w;
  logic [1:0]    s1_sel;
  logic          s1_neg, s1_pass;

  always_comb begin
    c1_rg_max = (s0_r > s0_g) ? s0_r : s0_g;
    c1_rg_min = (s0_r < s0_g) ? s0_r : s0_g;
    c1_max    = (s0_b > c1_rg_max) ? s0_b : c1_rg_max;
    c1_min    = (s0_b < c1_rg_min) ? s0_b : c1_rg_min;
    // red wins ties, then green
    if (c1_max == s0_r)      c1_sel = hsvis_pkg::SEL_RED;
    else if (c1_max == s0_g) c1_sel = hsvis_pkg::SEL_GREEN;
    else                     c1_sel = hsvis_pkg::SEL_BLUE;
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s1_r    <= s0_r;
      s1_g    <= s0_g;
      s1_b    <= s0_b;
      s1_max  <= c1_max;
      s1_min  <= c1_min;
      s1_sel  <= c1_sel;
      s1_w    <= s0_w;
      s1_neg  <= s0_neg;
      s1_pass <= s0_pass;
    end
  end

  // --------------------------------------------------------------------------
  // stage 2: delta, hue numerator magnitude, sector base and direction
  // --------------------------------------------------------------------------
  logic [CW-1:0] c2_ha, c2_hb, c2_num;
  logic [2:0]    c2_base;
  logic          c2_hneg;
  logic [CW-1:0] s2_delta, s2_num;
  hsvis_pkg::side_t s2_side;

  always_comb begin
    case (s1_sel)
      hsvis_pkg::SEL_RED: begin
        c2_ha = s1_g;
        c2_hb = s1_b;
      end
      hsvis_pkg::SEL_GREEN: begin
        c2_ha = s1_b;
        c2_hb = s1_r;
      end
      default: begin
        c2_ha = s1_r;
        c2_hb = s1_g;
      end
    endcase
    c2_hneg = c2_ha < c2_hb;
    c2_num  = c2_hneg ? (c2_hb - c2_ha) : (c2_ha - c2_hb);
    case (s1_sel)
      // red sector counts down from six when green is below blue
      hsvis_pkg::SEL_RED:   c2_base = c2_hneg ? 3'd6 : 3'd0;
      hsvis_pkg::SEL_GREEN: c2_base = 3'd2;
      default:              c2_base = 3'd4;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s2_delta           <= s1_max - s1_min;
      s2_num             <= c2_num;
      s2_side.r          <= s1_r;
      s2_side.g          <= s1_g;
      s2_side.b          <= s1_b;
      s2_side.cmax       <= s1_max;
      s2_side.delta_zero <= (s1_max == s1_min);
      s2_side.base       <= c2_base;
      s2_side.hneg       <= c2_hneg;
      s2_side.w          <= s1_w;
      s2_side.neg        <= s1_neg;
      s2_side.pass       <= s1_pass;
    end
  end

  // --------------------------------------------------------------------------
  // dividers: hue fraction num/delta and saturation delta/max
  // --------------------------------------------------------------------------
  logic [QW-1:0] hue_quo, sat_quo;
  hsvis_pkg::side_t side_q [QW];

  hsvis_div u_hue_div (
    .clk (clk),
    .en  (en[SD +: QW]),
    .num (s2_num),
    .den (s2_delta),
    .quo (hue_quo)
  );

  hsvis_div u_sat_div (
    .clk (clk),
    .en  (en[SD +: QW]),
    .num (s2_delta),
    .den (s2_side.cmax),
    .quo (sat_quo)
  );

  always_ff @(posedge clk) begin
    if (en[SD]) side_q[0] <= s2_side;
    for (int j = 1; j < QW; j++) begin
      if (en[SD+j]) side_q[j] <= side_q[j-1];
    end
  end

  // --------------------------------------------------------------------------
  // hue assembly with wrap, and the four blend products
  // --------------------------------------------------------------------------
  hsvis_pkg::side_t dq;
  logic [hsvis_pkg::HW-1:0] ch_base, ch_hue, ch_wrap;
  logic [CW-1:0] ch_s, ch_keep, ch_tgt_s, ch_tgt_v;
  logic [hsvis_pkg::PW-1:0] sh_ps1, sh_ps2, sh_pv1, sh_pv2;
  logic [CW-1:0] sh_s, sh_r, sh_g, sh_b;
  logic [2:0]    sh_sector;
  logic [hsvis_pkg::FRAC_BITS-1:0] sh_f;
  logic          sh_pass;

  always_comb begin
    dq       = side_q[QW-1];
    ch_base  = hsvis_pkg::HW'(dq.base) << hsvis_pkg::FRAC_BITS;
    ch_hue   = dq.hneg ? (ch_base - hsvis_pkg::HW'(hue_quo))
                       : (ch_base + hsvis_pkg::HW'(hue_quo));
    // grey pixel: hue and saturation are zero
    if (dq.delta_zero)                   ch_wrap = '0;
    else if (ch_hue >= hsvis_pkg::HUE_WRAP) ch_wrap = ch_hue - hsvis_pkg::HUE_WRAP;
    else                                 ch_wrap = ch_hue;
    ch_s     = dq.delta_zero ? '0 : CW'(sat_quo);
    ch_keep  = hsvis_pkg::ONE - dq.w;
    ch_tgt_s = dq.neg ? hsvis_pkg::sat_one(dark_saturation)
                      : hsvis_pkg::sat_one(bright_saturation);
    ch_tgt_v = dq.neg ? hsvis_pkg::sat_one(dark_value)
                      : hsvis_pkg::sat_one(bright_value);
  end

  always_ff @(posedge clk) begin
    if (en[SH]) begin
      sh_ps1    <= hsvis_pkg::PW'(ch_keep) * hsvis_pkg::PW'(ch_s);
      sh_ps2    <= hsvis_pkg::PW'(dq.w) * hsvis_pkg::PW'(ch_tgt_s);
      sh_pv1    <= hsvis_pkg::PW'(ch_keep) * hsvis_pkg::PW'(dq.cmax);
      sh_pv2    <= hsvis_pkg::PW'(dq.w) * hsvis_pkg::PW'(ch_tgt_v);
      sh_s      <= ch_s;
      sh_sector <= ch_wrap[hsvis_pkg::HW-1 -: 3];
      sh_f      <= ch_wrap[hsvis_pkg::FRAC_BITS-1:0];
      sh_r      <= dq.r;
      sh_g      <= dq.g;
      sh_b      <= dq.b;
      sh_pass   <= dq.pass;
    end
  end

  // --------------------------------------------------------------------------
  // blend sums with rounding and clamp; saturation stays zero when grey
  // --------------------------------------------------------------------------
  logic [hsvis_pkg::PW:0] cb_ssum, cb_vsum;
  logic [CW:0]   cb_s, cb_v;
  logic [CW-1:0] sb_s, sb_v, sb_r, sb_g, sb_b;
  logic [2:0]    sb_sector;
  logic [hsvis_pkg::FRAC_BITS-1:0] sb_f;
  logic          sb_pass;

  always_comb begin
    cb_ssum = (hsvis_pkg::PW+1)'(sh_ps1) + (hsvis_pkg::PW+1)'(sh_ps2)
            + (hsvis_pkg::PW+1)'(hsvis_pkg::HALF);
    cb_vsum = (hsvis_pkg::PW+1)'(sh_pv1) + (hsvis_pkg::PW+1)'(sh_pv2)
            + (hsvis_pkg::PW+1)'(hsvis_pkg::HALF);
    cb_s    = (CW+1)'(cb_ssum >> hsvis_pkg::FRAC_BITS);
    cb_v    = (CW+1)'(cb_vsum >> hsvis_pkg::FRAC_BITS);
  end

  always_ff @(posedge clk) begin
    if (en[SB]) begin
      if (sh_s == '0)                            sb_s <= '0;
      else if (cb_s > (CW+1)'(hsvis_pkg::ONE))   sb_s <= hsvis_pkg::ONE;
      else                                       sb_s <= CW'(cb_s);
      sb_v      <= (cb_v > (CW+1)'(hsvis_pkg::ONE)) ? hsvis_pkg::ONE : CW'(cb_v);
      sb_sector <= sh_sector;
      sb_f      <= sh_f;
      sb_r      <= sh_r;
      sb_g      <= sh_g;
      sb_b      <= sh_b;
      sb_pass   <= sh_pass;
    end
  end

  // --------------------------------------------------------------------------
  // hsv to rgb, first products: v*(1-s), f*s, (1-f)*s
  // --------------------------------------------------------------------------
  logic [hsvis_pkg::PW-1:0] sp_pprod;
  logic [hsvis_pkg::WW-1:0] sp_fs, sp_gs;
  logic [CW-1:0] sp_v, sp_r, sp_g, sp_b;
  logic [2:0]    sp_sector;
  logic          sp_pass;

  always_ff @(posedge clk) begin
    if (en[SP]) begin
      sp_pprod  <= hsvis_pkg::PW'(sb_v) * hsvis_pkg::PW'(hsvis_pkg::ONE - sb_s);
      sp_fs     <= hsvis_pkg::WW'(sb_f) * hsvis_pkg::WW'(sb_s);
      sp_gs     <= hsvis_pkg::WW'(hsvis_pkg::ONE - CW'(sb_f)) * hsvis_pkg::WW'(sb_s);
      sp_v      <= sb_v;
      sp_sector <= sb_sector;
      sp_r      <= sb_r;
      sp_g      <= sb_g;
      sp_b      <= sb_b;
      sp_pass   <= sb_pass;
    end
  end

  // --------------------------------------------------------------------------
  // long products for q and t, rounded p
  // --------------------------------------------------------------------------
  logic [hsvis_pkg::LW-1:0] sq_qprod, sq_tprod;
  logic [hsvis_pkg::PW-1:0] cq_psum;
  logic [CW-1:0] sq_p, sq_v, sq_r, sq_g, sq_b;
  logic [2:0]    sq_sector;
  logic          sq_pass;

  assign cq_psum = sp_pprod + hsvis_pkg::HALF;

  always_ff @(posedge clk) begin
    if (en[SQ]) begin
      sq_qprod  <= hsvis_pkg::LW'(sp_v) * hsvis_pkg::LW'(hsvis_pkg::ONE_SQ - sp_fs);
      sq_tprod  <= hsvis_pkg::LW'(sp_v) * hsvis_pkg::LW'(hsvis_pkg::ONE_SQ - sp_gs);
      sq_p      <= CW'(cq_psum >> hsvis_pkg::FRAC_BITS);
      sq_v      <= sp_v;
      sq_sector <= sp_sector;
      sq_r      <= sp_r;
      sq_g      <= sp_g;
      sq_b      <= sp_b;
      sq_pass   <= sp_pass;
    end
  end

  // --------------------------------------------------------------------------
  // output register: round q and t, pick channels by sector
  // --------------------------------------------------------------------------
  logic [hsvis_pkg::LW-1:0] co_qsum, co_tsum;
  logic [CW-1:0] co_q, co_t, co_r, co_g, co_b;

  always_comb begin
    co_qsum = sq_qprod + hsvis_pkg::HALF_SQ;
    co_tsum = sq_tprod + hsvis_pkg::HALF_SQ;
    co_q    = CW'(co_qsum >> (2 * hsvis_pkg::FRAC_BITS));
    co_t    = CW'(co_tsum >> (2 * hsvis_pkg::FRAC_BITS));
    case (sq_sector)
      3'd0: begin co_r = sq_v; co_g = co_t; co_b = sq_p; end
      3'd1: begin co_r = co_q; co_g = sq_v; co_b = sq_p; end
      3'd2: begin co_r = sq_p; co_g = sq_v; co_b = co_t; end
      3'd3: begin co_r = sq_p; co_g = co_q; co_b = sq_v; end
      3'd4: begin co_r = co_t; co_g = sq_p; co_b = sq_v; end
      default: begin co_r = sq_v; co_g = sq_p; co_b = co_q; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[SO]) begin
      red_out   <= sq_pass ? sq_r : co_r;
      green_out <= sq_pass ? sq_g : co_g;
      blue_out  <= sq_pass ? sq_b : co_b;
    end
  end

endmodule

/* design/hsvis_check.sv */
// ----------------------------------------------------------------------------
// hsvis_check
// port-level checks of the hsv illumination shader, bound to the top level
// ----------------------------------------------------------------------------
module hsvis_check (
  input logic                      clk,
  input logic                      rst,
  input logic                      in_valid,
  input logic                      in_stall,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic [hsvis_pkg::CW-1:0]  red_out,
  input logic [hsvis_pkg::CW-1:0]  green_out,
  input logic [hsvis_pkg::CW-1:0]  blue_out
);

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  // an empty output register never holds back the input
  a_no_false_stall: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty output");

  // shaded channels stay within one
  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (red_out <= hsvis_pkg::ONE) && (green_out <= hsvis_pkg::ONE)
                  && (blue_out <= hsvis_pkg::ONE))
    else $error("output channel above one");

  // a stalled item holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(red_out) && $stable(green_out)
                               && $stable(blue_out))
    else $error("stalled output item changed");

endmodule

bind hsv_illumination_shade_core hsvis_check u_hsvis_check (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .red_out   (red_out),
  .green_out (green_out),
  .blue_out  (blue_out)
);
